>>> sv/pnguf_pkg.sv
// shared types, constants and codes for the png scanline unfilter
package pnguf_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int CHANNELS     = 4;
  localparam int HEIGHT_LIMIT = 32768;
  localparam int STORE_DEPTH  = MAX_WIDTH * CHANNELS;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int CHAN_W   = $clog2(CHANNELS);
  localparam int ROW_W    = $clog2(HEIGHT_LIMIT);
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // queue entry kinds
  localparam logic KIND_COLOR = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // one unit of work passed from the front to the back
  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [2:0]        filt;
    logic [CHAN_W-1:0] chan;
    logic [ADDR_W-1:0] addr;
    logic              row0;
    logic              col0;
    logic              rend;
    logic              iend;
  } entry_t;

endpackage

>>> sv/pnguf_ram.sv
// generic single write port ram with registered read
module pnguf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/pnguf_front.sv
// front: accepts bytes, tracks row and column position, classifies work
module pnguf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  input  logic [0:0]                    s_tuser,
  input  logic [pnguf_pkg::WIDTH_W-1:0]  image_width,
  input  logic [pnguf_pkg::HEIGHT_W-1:0] image_height,
  input  logic                          fifo_full,
  output logic                          push,
  output pnguf_pkg::entry_t             entry
);
  import pnguf_pkg::*;

  logic [COL_W-1:0]    column;
  logic [CHAN_W-1:0]   chan;
  logic [ROW_W-1:0]    row;
  logic [2:0]          filt;
  logic                expect_type;
  logic                error_hold;

  logic [COL_W-1:0]    column_next;
  logic [CHAN_W-1:0]   chan_next;
  logic [ROW_W-1:0]    row_next;
  logic [2:0]          filt_next;
  logic                expect_type_next;
  logic                error_hold_next;

  logic                accept;
  logic                start;
  logic [COL_W-1:0]    col_e;
  logic [CHAN_W-1:0]   chan_e;
  logic [ROW_W-1:0]    row_e;
  logic                exp_e;
  logic                err_e;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [WIDTH_W-1:0]  col_inc;
  logic [HEIGHT_W-1:0] row_inc;
  logic                last;
  logic                rend;
  logic                iend;
  logic                bad_type;

  assign s_tready = !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign start    = s_tuser[0];

  always_comb begin
    // out of range widths and heights clamp
    if (image_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (image_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
      eff_h = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = image_height;
    end
  end

  always_comb begin
    // start mark clears the position before the byte is looked at
    col_e  = start ? '0 : column;
    chan_e = start ? '0 : chan;
    row_e  = start ? '0 : row;
    exp_e  = start ? 1'b1 : expect_type;
    err_e  = start ? 1'b0 : error_hold;

    col_inc  = WIDTH_W'(col_e) + WIDTH_W'(1);
    row_inc  = HEIGHT_W'(row_e) + HEIGHT_W'(1);
    last     = (chan_e == CHAN_W'(CHANNELS - 1));
    rend     = last && (col_inc >= eff_w);
    iend     = rend && (row_inc >= eff_h);
    bad_type = (s_tdata > 8'(FILT_PAETH));

    column_next      = col_e;
    chan_next        = chan_e;
    row_next         = row_e;
    filt_next        = filt;
    expect_type_next = exp_e;
    error_hold_next  = err_e;
    push             = 1'b0;

    entry.kind = exp_e ? KIND_ERROR : KIND_COLOR;
    entry.data = s_tdata;
    entry.filt = filt;
    entry.chan = chan_e;
    entry.addr = {col_e, chan_e};
    entry.row0 = (row_e == '0);
    entry.col0 = (col_e == '0);
    entry.rend = rend;
    entry.iend = iend;

    if (accept && !err_e) begin
      if (exp_e) begin
        if (bad_type) begin
          error_hold_next = 1'b1;
          push            = 1'b1;
        end else begin
          filt_next        = s_tdata[2:0];
          column_next      = '0;
          chan_next        = '0;
          expect_type_next = 1'b0;
        end
      end else begin
        push = 1'b1;
        if (!last) begin
          chan_next = chan_e + CHAN_W'(1);
        end else begin
          chan_next = '0;
          if (rend) begin
            column_next      = '0;
            expect_type_next = 1'b1;
            row_next         = iend ? '0 : row_inc[ROW_W-1:0];
          end else begin
            column_next = col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      chan        <= '0;
      row         <= '0;
      filt        <= FILT_NONE;
      expect_type <= 1'b1;
      error_hold  <= 1'b0;
    end else if (accept) begin
      column      <= column_next;
      chan        <= chan_next;
      row         <= row_next;
      filt        <= filt_next;
      expect_type <= expect_type_next;
      error_hold  <= error_hold_next;
    end
  end

  a_bad_start_errors: assert property (@(posedge clk) disable iff (rst)
    accept && start && bad_type |-> push && entry.kind == KIND_ERROR)
    else $error("bad filter type on start mark did not queue an error");

  a_hold_drops: assert property (@(posedge clk) disable iff (rst)
    error_hold && !(accept && start) |-> !push)
    else $error("work queued while in error hold");

  a_rend_on_last: assert property (@(posedge clk) disable iff (rst)
    push && entry.kind == KIND_COLOR && !last |-> !entry.rend)
    else $error("row end marked on a byte that does not close a pixel");

endmodule

>>> sv/pnguf_fifo.sv
// short queue of work entries between front and back
module pnguf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pnguf_pkg::entry_t push_entry,
  input  logic              pop,
  output pnguf_pkg::entry_t head,
  output logic              full,
  output logic              empty
);
  import pnguf_pkg::*;

  entry_t                slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (FIFO_PTR_W + 1)'(1);
        2'b01:   count <= count - (FIFO_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
    else $error("queue count past depth");

endmodule

>>> sv/pnguf_back.sv
// back: line store, filter reconstruction and pixel output register
module pnguf_back (
  input  logic              clk,
  input  logic              rst,
  input  pnguf_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic              m_tlast,
  output logic [1:0]        m_tuser
);
  import pnguf_pkg::*;

  logic        s1_valid;
  entry_t      s1;
  logic [7:0]  upper;
  logic [7:0]  left_px  [CHANNELS];
  logic [7:0]  upl_px   [CHANNELS];
  logic [7:0]  partial  [CHANNELS-1];

  logic        s1_last;
  logic        needs_out;
  logic        out_free;
  logic        s1_adv;
  logic        ram_we;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [8:0]  ab_sum;
  logic signed [9:0] pa_d;
  logic signed [9:0] pb_d;
  logic signed [9:0] pc_d;
  logic [9:0]  pa;
  logic [9:0]  pb;
  logic [9:0]  pc;
  logic [7:0]  pred;
  logic [7:0]  v;

  assign s1_last   = (s1.chan == CHAN_W'(CHANNELS - 1));
  assign needs_out = (s1.kind == KIND_ERROR) || s1_last;
  assign out_free  = !m_tvalid || m_tready;
  assign s1_adv    = s1_valid && (!needs_out || out_free);
  assign pop       = !empty && (!s1_valid || s1_adv);
  assign ram_we    = s1_adv && (s1.kind == KIND_COLOR);

  // read is issued as the entry leaves the queue, data lines up with s1
  pnguf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.addr),
    .wdata (v),
    .re    (pop),
    .raddr (head.addr),
    .rdata (upper)
  );

  always_comb begin
    a      = s1.col0 ? 8'd0 : left_px[s1.chan];
    c      = s1.col0 ? 8'd0 : upl_px[s1.chan];
    b      = s1.row0 ? 8'd0 : upper;
    ab_sum = {1'b0, a} + {1'b0, b};
    // paeth distances: |b-c|, |a-c|, |a+b-2c|
    pa_d   = $signed({2'b00, b}) - $signed({2'b00, c});
    pb_d   = $signed({2'b00, a}) - $signed({2'b00, c});
    pc_d   = $signed({1'b0, ab_sum}) - $signed({1'b0, c, 1'b0});
    pa     = pa_d[9] ? 10'(-pa_d) : 10'(pa_d);
    pb     = pb_d[9] ? 10'(-pb_d) : 10'(pb_d);
    pc     = pc_d[9] ? 10'(-pc_d) : 10'(pc_d);
    unique case (s1.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    v = s1.data + pred;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= head;
    end
    if (ram_we) begin
      left_px[s1.chan] <= v;
      upl_px[s1.chan]  <= b;
      if (!s1_last) begin
        partial[s1.chan] <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && needs_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && needs_out) begin
      if (s1.kind == KIND_ERROR) begin
        m_tdata <= '0;
        m_tlast <= 1'b0;
        m_tuser <= 2'b10;
      end else begin
        m_tdata <= {v, partial[0], partial[1], partial[2]};
        m_tlast <= s1.iend;
        m_tuser <= {1'b0, s1.rend};
      end
    end
  end

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.kind == KIND_ERROR |=> m_tvalid && m_tuser[1] && m_tdata == '0)
    else $error("error entry did not produce a clean error result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(s1_adv && needs_out))
    else $error("pending result overwritten");

endmodule

>>> sv/png_scanline_unfilter.sv
// png scanline filter reconstruction for 8-bit rgba, one byte per cycle while the queue has room
// throughput: one inflated byte per cycle while the queue has room, one bgra pixel per four color bytes
// an alpha byte passes the queue, the s1 stage and the output register before its result is valid
// the line store read and the reconstruction share the s1 stage behind the queue
// reset (rst, synchronous) clears position, error hold, queue and output valid
// the line store has no clear pass: row 0 ignores what it reads, later rows read what the row above wrote
module png_scanline_unfilter (
  input  logic                         clk,
  input  logic                         rst,
  // input stream of inflated bytes
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  input  logic [0:0]                   s_tuser,   // [0] start_image
  // output stream of pixels
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // [7:0] blue, [15:8] green, [23:16] red,
                                                  // [31:24] alpha
  output logic                         m_tlast,   // image_end
  output logic [1:0]                   m_tuser,   // [0] row_end, [1] bad_filter
  // configuration write port
  input  logic                         cfg_wen,
  input  logic [0:0]                   cfg_index,
  input  logic [pnguf_pkg::CFG_W-1:0]  cfg_wdata
);
  import pnguf_pkg::*;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;

  logic   push;
  entry_t push_entry;
  entry_t head;
  logic   fifo_full;
  logic   fifo_empty;
  logic   pop;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(1);
      image_height <= HEIGHT_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_index[0])
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata[HEIGHT_W-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  // front: position tracking, filter type decode, error hold
  pnguf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .image_width  (image_width),
    .image_height (image_height),
    .fifo_full    (fifo_full),
    .push         (push),
    .entry        (push_entry)
  );

  // decouples byte intake from output back-pressure
  pnguf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (fifo_full),
    .empty      (fifo_empty)
  );

  // back: line store, predictor, pixel assembly and output register
  pnguf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (fifo_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
